// File: src/kwm_pkg.sv
package kwm_pkg;

    // Lane count and derived widths
    localparam int LANES    = 8;
    localparam int LANE_W   = $clog2(LANES);
    localparam int CNT_W    = $clog2(LANES + 1);
    localparam int TREE_LVL = LANE_W;
    localparam int PAD      = 1 << LANE_W;

    // Field widths
    localparam int ACT_W  = 2;
    localparam int LID_W  = 3;
    localparam int KEY_W  = 32;
    localparam int TAG_W  = 8;
    localparam int KIND_W = 2;
    localparam int CFG_W  = 4;

    // Action codes on the request channel
    localparam logic [ACT_W-1:0] ACT_DELIVER = 2'd0;
    localparam logic [ACT_W-1:0] ACT_EXHAUST = 2'd1;
    localparam logic [ACT_W-1:0] ACT_START   = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_ELEM  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

    // Lower bound of the pass lane count; also the lane count register's reset value
    localparam int MIN_LANES = 2;

    // Decoded operation handed from front to back
    typedef enum logic [1:0] {
        OP_DELIVER,
        OP_EXHAUST,
        OP_START,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [LID_W-1:0]        lane;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic [LID_W-1:0]        lane;
        logic                    new_run;
    } result_t;

endpackage

// File: src/kwm_if.sv
interface kwm_in_if import kwm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic [LID_W-1:0]        lane;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;

    modport source (output valid, output action, output lane, output key, output tag,
                    input ready);
    modport sink   (input valid, input action, input lane, input key, input tag,
                    output ready);
endinterface

interface kwm_out_if import kwm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] out_key;
    logic [TAG_W-1:0]        out_tag;
    logic [LID_W-1:0]        source_lane;
    logic                    new_run;

    modport source (output valid, output kind, output out_key, output out_tag,
                    output source_lane, output new_run, input ready);
    modport sink   (input valid, input kind, input out_key, input out_tag,
                    input source_lane, input new_run, output ready);
endinterface

// File: src/kwm_front.sv
module kwm_front import kwm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    kwm_in_if.sink  req,
    output item_t   item,
    output logic    item_valid,
    input  logic    item_pop
);

    localparam int QD = 2;

    item_t      q_reg [QD];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    item_t      dec;
    logic       push;
    logic       pop;

    // Decode the action into an operation
    always_comb
    begin
        case (req.action)
            ACT_DELIVER: dec.op = OP_DELIVER;
            ACT_EXHAUST: dec.op = OP_EXHAUST;
            ACT_START:   dec.op = OP_START;
            default:     dec.op = OP_BAD;
        endcase
        dec.lane = req.lane;
        dec.key  = req.key;
        dec.tag  = req.tag;
    end

    // Take an item while the queue has room
    assign req.ready  = (cnt_reg != 2'(QD));
    assign push       = req.valid && req.ready;
    assign pop        = item_pop && (cnt_reg != 2'd0);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the decoded item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// File: src/kwm_back.sv
module kwm_back import kwm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  item_t            item,
    input  logic             item_valid,
    output logic             item_pop,
    input  logic [CFG_W-1:0] active_lanes,
    kwm_out_if.source        rsp
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_PRIME  = 3'b010,
        PH_REFILL = 3'b100
    } phase_t;

    typedef struct packed {
        logic                    v;
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic [LID_W-1:0]        lane;
        logic [LANE_W-1:0]       idx;
    } node_t;

    // Slot table: head entry of the lane held in each order slot
    logic signed [KEY_W-1:0] slot_key_reg  [LANES];
    logic [TAG_W-1:0]        slot_tag_reg  [LANES];
    logic [LID_W-1:0]        slot_lane_reg [LANES];
    logic signed [KEY_W-1:0] slot_key_next [LANES];
    logic [TAG_W-1:0]        slot_tag_next [LANES];
    logic [LID_W-1:0]        slot_lane_next[LANES];

    phase_t            phase_reg, phase_next, phase_upd;
    logic [CNT_W-1:0]  live_count_reg, live_count_next, live_upd;
    logic [CNT_W-1:0]  open_count_reg, open_count_next, open_upd;
    logic [CNT_W-1:0]  prime_count_reg, prime_count_next, prime_upd;
    logic [CNT_W-1:0]  pass_lanes_reg, pass_lanes_next, pass_upd;
    logic [LID_W-1:0]  expected_lane_reg, expected_lane_next;
    logic [LANE_W-1:0] chosen_slot_reg, chosen_slot_next;
    logic              pending_reg, pending_next, pending_upd;

    logic              rsp_valid_reg;
    result_t           rsp_data_reg;

    logic              go;
    logic              emit_req;
    logic              err;
    logic              res_fire;
    result_t           res;
    logic [CNT_W-1:0]  open_fin;
    logic              reopen;
    node_t             tr [TREE_LVL+1][PAD];
    node_t             best;

    // Execute one queued item whenever the result slot can take its result
    assign go       = item_valid && (!rsp_valid_reg || rsp.ready);
    assign item_pop = go;

    // Apply start, priming and refill updates to the counters and slot table
    always_comb
    begin
        logic [LANE_W-1:0]       cs;
        logic [LANE_W-1:0]       ia;
        logic [LANE_W-1:0]       ib;
        logic                    ended;
        logic signed [KEY_W-1:0] tk;
        logic [TAG_W-1:0]        tt;
        logic [LID_W-1:0]        tl;

        slot_key_next  = slot_key_reg;
        slot_tag_next  = slot_tag_reg;
        slot_lane_next = slot_lane_reg;
        phase_upd      = phase_reg;
        live_upd       = live_count_reg;
        open_upd       = open_count_reg;
        prime_upd      = prime_count_reg;
        pass_upd       = pass_lanes_reg;
        pending_upd    = pending_reg;
        emit_req       = 1'b0;
        err            = 1'b0;
        cs             = chosen_slot_reg;
        ended          = 1'b0;
        ia             = '0;
        ib             = '0;
        tk             = '0;
        tt             = '0;
        tl             = '0;

        if (go)
        begin
            case (item.op)
                OP_START:
                begin
                    if (active_lanes < CFG_W'(MIN_LANES))
                        pass_upd = CNT_W'(MIN_LANES);
                    else if (32'(active_lanes) > LANES)
                        pass_upd = CNT_W'(LANES);
                    else
                        pass_upd = CNT_W'(active_lanes);
                    live_upd    = '0;
                    open_upd    = '0;
                    prime_upd   = '0;
                    pending_upd = 1'b1;
                    phase_upd   = PH_PRIME;
                end
                OP_DELIVER, OP_EXHAUST:
                begin
                    if (phase_reg == PH_PRIME)
                    begin
                        if (32'(item.lane) == 32'(prime_count_reg) &&
                            prime_count_reg < pass_lanes_reg)
                        begin
                            // Live lanes fill from slot 0; exhausted ones are never read
                            if (item.op == OP_DELIVER)
                            begin
                                ia                 = LANE_W'(live_count_reg);
                                slot_key_next[ia]  = item.key;
                                slot_tag_next[ia]  = item.tag;
                                slot_lane_next[ia] = item.lane;
                                live_upd           = live_count_reg + CNT_W'(1);
                            end
                            prime_upd = prime_count_reg + CNT_W'(1);
                            if (prime_upd == pass_lanes_reg)
                            begin
                                open_upd = live_upd;
                                emit_req = 1'b1;
                            end
                        end
                        else
                        begin
                            err = 1'b1;
                        end
                    end
                    else if (phase_reg == PH_REFILL)
                    begin
                        if (item.lane == expected_lane_reg)
                        begin
                            // A smaller key or exhaustion closes the lane's run
                            ended = (item.op == OP_EXHAUST) ||
                                    (item.key < slot_key_reg[cs]);
                            if (item.op == OP_DELIVER)
                            begin
                                slot_key_next[cs] = item.key;
                                slot_tag_next[cs] = item.tag;
                            end
                            // Move a closed run behind the open part
                            if (ended)
                            begin
                                open_upd           = open_count_reg - CNT_W'(1);
                                ia                 = LANE_W'(open_upd);
                                tk                 = slot_key_next[ia];
                                tt                 = slot_tag_next[ia];
                                tl                 = slot_lane_next[ia];
                                slot_key_next[ia]  = slot_key_next[cs];
                                slot_tag_next[ia]  = slot_tag_next[cs];
                                slot_lane_next[ia] = slot_lane_next[cs];
                                slot_key_next[cs]  = tk;
                                slot_tag_next[cs]  = tt;
                                slot_lane_next[cs] = tl;
                            end
                            // Move an exhausted lane behind the live part
                            if (item.op == OP_EXHAUST)
                            begin
                                live_upd           = live_count_reg - CNT_W'(1);
                                ia                 = LANE_W'(open_upd);
                                ib                 = LANE_W'(live_upd);
                                tk                 = slot_key_next[ia];
                                tt                 = slot_tag_next[ia];
                                tl                 = slot_lane_next[ia];
                                slot_key_next[ia]  = slot_key_next[ib];
                                slot_tag_next[ia]  = slot_tag_next[ib];
                                slot_lane_next[ia] = slot_lane_next[ib];
                                slot_key_next[ib]  = tk;
                                slot_tag_next[ib]  = tt;
                                slot_lane_next[ib] = tl;
                            end
                            emit_req = 1'b1;
                        end
                        else
                        begin
                            err = 1'b1;
                        end
                    end
                    else
                    begin
                        err = 1'b1;
                    end
                end
                default:
                begin
                    err = 1'b1;
                end
            endcase
        end
    end

    // Reopen all live lanes once every run has closed
    assign reopen   = (open_upd == '0);
    assign open_fin = reopen ? live_upd : open_upd;

    // Pick the smallest open head; ties keep the lower slot
    always_comb
    begin
        tr = '{default: '0};
        for (int s = 0; s < PAD; s++)
        begin
            if (s < LANES)
            begin
                tr[0][s].v    = (CNT_W'(s) < open_fin);
                tr[0][s].key  = slot_key_next[s];
                tr[0][s].tag  = slot_tag_next[s];
                tr[0][s].lane = slot_lane_next[s];
                tr[0][s].idx  = LANE_W'(s);
            end
        end
        for (int lv = 1; lv <= TREE_LVL; lv++)
        begin
            for (int s = 0; s < (PAD >> lv); s++)
            begin
                if (tr[lv-1][2*s+1].v && (!tr[lv-1][2*s].v ||
                    ($signed(tr[lv-1][2*s+1].key) < $signed(tr[lv-1][2*s].key))))
                    tr[lv][s] = tr[lv-1][2*s+1];
                else
                    tr[lv][s] = tr[lv-1][2*s];
            end
        end
    end

    assign best = tr[TREE_LVL][0];

    // Form the result and the final next state
    always_comb
    begin
        phase_next         = phase_upd;
        live_count_next    = live_upd;
        open_count_next    = open_upd;
        prime_count_next   = prime_upd;
        pass_lanes_next    = pass_upd;
        pending_next       = pending_upd;
        expected_lane_next = expected_lane_reg;
        chosen_slot_next   = chosen_slot_reg;
        res                = '0;
        res_fire           = 1'b0;

        if (err)
        begin
            res.kind = KIND_ERROR;
            res_fire = 1'b1;
        end
        else if (emit_req)
        begin
            res_fire = 1'b1;
            if (live_upd == '0)
            begin
                res.kind   = KIND_DONE;
                phase_next = PH_IDLE;
            end
            else
            begin
                res.kind           = KIND_ELEM;
                res.key            = best.key;
                res.tag            = best.tag;
                res.lane           = best.lane;
                res.new_run        = pending_upd || reopen;
                open_count_next    = open_fin;
                pending_next       = 1'b0;
                chosen_slot_next   = best.idx;
                expected_lane_next = best.lane;
                phase_next         = PH_REFILL;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            live_count_reg    <= '0;
            open_count_reg    <= '0;
            prime_count_reg   <= '0;
            pass_lanes_reg    <= CNT_W'(MIN_LANES);
            pending_reg       <= 1'b0;
            expected_lane_reg <= '0;
            chosen_slot_reg   <= '0;
            rsp_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            live_count_reg    <= live_count_next;
            open_count_reg    <= open_count_next;
            prime_count_reg   <= prime_count_next;
            pass_lanes_reg    <= pass_lanes_next;
            pending_reg       <= pending_next;
            expected_lane_reg <= expected_lane_next;
            chosen_slot_reg   <= chosen_slot_next;
            if (go && res_fire)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Slot table and result payload
    always_ff @(posedge clk)
    begin
        slot_key_reg  <= slot_key_next;
        slot_tag_reg  <= slot_tag_next;
        slot_lane_reg <= slot_lane_next;
        if (go && res_fire)
            rsp_data_reg <= res;
    end

    // Drive the result channel
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.kind        = rsp_data_reg.kind;
    assign rsp.out_key     = rsp_data_reg.key;
    assign rsp.out_tag     = rsp_data_reg.tag;
    assign rsp.source_lane = rsp_data_reg.lane;
    assign rsp.new_run     = rsp_data_reg.new_run;

    a_open_le_live: assert property (@(posedge clk) disable iff (!rst_n)
        open_count_reg <= live_count_reg)
        else $error("open lanes exceed live lanes");

    a_live_le_pass: assert property (@(posedge clk) disable iff (!rst_n)
        live_count_reg <= pass_lanes_reg)
        else $error("live lanes exceed pass lanes");

    a_refill_open: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_REFILL |-> open_count_reg != '0)
        else $error("refill pending with no open run");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (go && res_fire && res.kind == KIND_DONE) |=> phase_reg == PH_IDLE)
        else $error("pass done without returning to idle");

endmodule

// File: src/kwm_top_placeholder.sv
module kwm_cfg import kwm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    output logic [CFG_W-1:0] active_lanes
);

    logic [CFG_W-1:0] active_lanes_reg;

    // Hold the lane count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_lanes_reg <= CFG_W'(MIN_LANES);
        else if (cfg_wr_en)
            active_lanes_reg <= cfg_wr_data;
    end

    assign active_lanes = active_lanes_reg;

endmodule

// File: src/kway_natural_run_merger_core.sv
// Channel   Dir   Payload                                       Handshake
// req       in    action, lane, key, tag                        valid/ready
// rsp       out   kind, out_key, out_tag, source_lane, new_run  valid/ready
// cfg       in    cfg_wr_data (active_lanes)                    cfg_wr_en
//
// One item per cycle sustained while rsp keeps up; the back end executes
// a whole item combinationally along the refill, slot swap and eight-way
// minimum tree path; an item waits in the queue, its result in a register.
// Reset (rst_n, asynchronous) clears control state only; no clearing pass.
// A two-entry queue parts front and back, so req takes up to two more items
// while rsp stalls.
module kway_natural_run_merger_core import kwm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    kwm_in_if.sink           req,
    kwm_out_if.source        rsp,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    item_t            item;
    logic             item_valid;
    logic             item_pop;
    logic [CFG_W-1:0] active_lanes;

    kwm_cfg u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .active_lanes (active_lanes)
    );

    kwm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop)
    );

    kwm_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_pop     (item_pop),
        .active_lanes (active_lanes),
        .rsp          (rsp)
    );

endmodule

// File: verif/tb_top.sv
module tb_top;
    import kwm_pkg::*;

    // Action code the block must reject
    localparam logic [ACT_W-1:0] ACT_BAD = 2'd3;

    localparam int ITEM_TARGET    = 1900;
    localparam int QUIET_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_CAP     = 200;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef enum logic [1:0] {
        MS_IDLE,
        MS_PRIME,
        MS_REFILL
    } merge_state_t;

    // Key patterns used to shape lane streams
    typedef enum logic [1:0] {
        KS_TIES,
        KS_FULL,
        KS_RUNS,
        KS_EDGES
    } key_style_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    kwm_in_if  req_if ();
    kwm_out_if rsp_if ();

    kway_natural_run_merger_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_if),
        .rsp         (rsp_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Merge predictor state
    logic [CFG_W-1:0]        lanes_reg;
    int                      pass_width;
    logic signed [KEY_W-1:0] head_key [LANES];
    logic [TAG_W-1:0]        head_tag [LANES];
    logic                    run_done [LANES];
    logic                    lane_dry [LANES];
    logic [LID_W-1:0]        slot_lane [LANES];
    int                      live_n;
    int                      open_n;
    int                      primed_n;
    merge_state_t            merge_state;
    logic [LID_W-1:0]        want_lane;
    int                      pick_slot;
    logic                    fresh_run;

    result_t due_results [$];

    // Stimulus state
    int                      burst_left;
    int                      items_sent;
    int                      lane_left [LANES];
    logic signed [KEY_W-1:0] lane_last [LANES];
    key_style_t              key_style;
    logic [15:0]             codes_written;

    // Checker state
    int fail_count;
    int elems_seen;
    int dones_seen;
    int errors_seen;
    int quiet_cycles;
    int ready_hold;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Clear per-pass state and reopen the identity order table
    function automatic void open_pass();
        for (int i = 0; i < LANES; i++) begin
            head_key[i]  = '0;
            head_tag[i]  = '0;
            run_done[i]  = 1'b0;
            lane_dry[i]  = 1'b0;
            slot_lane[i] = LID_W'(i);
        end
        live_n    = 0;
        open_n    = 0;
        primed_n  = 0;
        want_lane = '0;
        pick_slot = 0;
        fresh_run = 1'b1;
    endfunction

    function automatic void post_result(input logic [KIND_W-1:0] kind,
                                        input logic signed [KEY_W-1:0] key,
                                        input logic [TAG_W-1:0] tag,
                                        input logic [LID_W-1:0] lane,
                                        input logic nr);
        result_t r;
        r.kind    = kind;
        r.key     = key;
        r.tag     = tag;
        r.lane    = lane;
        r.new_run = nr;
        due_results.push_back(r);
    endfunction

    function automatic void swap_slots(input int a, input int b);
        logic [LID_W-1:0] t;
        t            = slot_lane[a];
        slot_lane[a] = slot_lane[b];
        slot_lane[b] = t;
    endfunction

    // Emit the smallest open head; reopen runs or end the pass as needed
    function automatic void emit_smallest();
        int               best;
        logic [LID_W-1:0] ln;
        if (live_n == 0) begin
            merge_state = MS_IDLE;
            post_result(KIND_DONE, '0, '0, '0, 1'b0);
        end else begin
            if (open_n == 0) begin
                for (int s = 0; s < live_n; s++)
                    run_done[slot_lane[s]] = lane_dry[slot_lane[s]];
                open_n    = live_n;
                fresh_run = 1'b1;
            end
            best = 0;
            for (int s = 1; s < open_n; s++)
                if (head_key[slot_lane[s]] < head_key[slot_lane[best]])
                    best = s;
            pick_slot   = best;
            ln          = slot_lane[best];
            want_lane   = ln;
            merge_state = MS_REFILL;
            post_result(KIND_ELEM, head_key[ln], head_tag[ln], ln, fresh_run);
            fresh_run = 1'b0;
        end
    endfunction

    // Advance the predictor by one accepted item
    function automatic void merge_step(input logic [ACT_W-1:0] action,
                                       input logic [LID_W-1:0] lane,
                                       input logic signed [KEY_W-1:0] key,
                                       input logic [TAG_W-1:0] tag);
        if (action == ACT_START) begin
            pass_width = int'(lanes_reg);
            if (pass_width < MIN_LANES)
                pass_width = MIN_LANES;
            if (pass_width > LANES)
                pass_width = LANES;
            open_pass();
            merge_state = MS_PRIME;
        end else if (action == ACT_BAD || merge_state == MS_IDLE) begin
            post_result(KIND_ERROR, '0, '0, '0, 1'b0);
        end else if (merge_state == MS_PRIME) begin
            if (int'(lane) != primed_n || primed_n >= pass_width) begin
                post_result(KIND_ERROR, '0, '0, '0, 1'b0);
            end else begin
                if (action == ACT_DELIVER) begin
                    head_key[lane]    = key;
                    head_tag[lane]    = tag;
                    slot_lane[live_n] = lane;
                    live_n++;
                end else begin
                    // exhausted lanes fill the table from the top down
                    lane_dry[lane] = 1'b1;
                    run_done[lane] = 1'b1;
                    slot_lane[pass_width - 1 - (primed_n - live_n)] = lane;
                end
                primed_n++;
                if (primed_n >= pass_width) begin
                    open_n = live_n;
                    emit_smallest();
                end
            end
        end else if (lane != want_lane) begin
            post_result(KIND_ERROR, '0, '0, '0, 1'b0);
        end else begin
            if (action == ACT_DELIVER) begin
                // a falling key closes the lane's run; an equal key does not
                if (key < head_key[lane])
                    run_done[lane] = 1'b1;
                head_key[lane] = key;
                head_tag[lane] = tag;
            end else begin
                lane_dry[lane] = 1'b1;
                run_done[lane] = 1'b1;
            end
            if (run_done[lane] && open_n > 0) begin
                if (open_n - 1 != pick_slot)
                    swap_slots(open_n - 1, pick_slot);
                open_n--;
            end
            if (lane_dry[lane] && live_n > 0) begin
                if (open_n != live_n - 1)
                    swap_slots(open_n, live_n - 1);
                live_n--;
            end
            emit_smallest();
        end
    endfunction

    // Offer one item in bursts with random gaps, then update the predictor
    task automatic send_item(input logic [ACT_W-1:0] action,
                             input logic [LID_W-1:0] lane,
                             input logic signed [KEY_W-1:0] key,
                             input logic [TAG_W-1:0] tag);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 3);
            if (gap != 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        req_if.valid  <= 1'b1;
        req_if.action <= action;
        req_if.lane   <= lane;
        req_if.key    <= key;
        req_if.tag    <= tag;
        do
            @(posedge clk);
        while (req_if.ready !== 1'b1);
        items_sent++;
        merge_step(action, lane, key, tag);
    endtask

    // Drop valid, drain every expected result, then let the pipe settle
    task automatic wait_quiet();
        req_if.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic set_lane_count(input logic [CFG_W-1:0] value);
        wait_quiet();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        lanes_reg = value;
        codes_written[value] = 1'b1;
    endtask

    // Next key of a lane stream in the current pattern
    function automatic logic signed [KEY_W-1:0] next_key(input int ln);
        logic signed [KEY_W-1:0] k;
        case (key_style)
            KS_TIES: k = KEY_W'($urandom_range(0, 4)) - 2;
            KS_FULL: k = $urandom;
            KS_RUNS:
                k = ($urandom_range(0, 5) == 0) ? lane_last[ln] - KEY_W'($urandom_range(1, 1000))
                                                : lane_last[ln] + KEY_W'($urandom_range(0, 40));
            default:
                case ($urandom_range(0, 4))
                    0:       k = KEY_MIN;
                    1:       k = KEY_MAX;
                    2:       k = '1;
                    3:       k = '0;
                    default: k = KEY_MIN + 1;
                endcase
        endcase
        lane_last[ln] = k;
        return k;
    endfunction

    // Wrong action or wrong lane; the block must answer with an error
    task automatic send_noise(input logic [LID_W-1:0] due_lane);
        if ($urandom_range(0, 2) == 0)
            send_item(ACT_BAD, LID_W'($urandom_range(0, 7)), $urandom,
                      TAG_W'($urandom_range(0, 255)));
        else
            send_item($urandom_range(0, 1) ? ACT_EXHAUST : ACT_DELIVER,
                      due_lane ^ LID_W'($urandom_range(1, 7)), $urandom,
                      TAG_W'($urandom_range(0, 255)));
    endtask

    task automatic test_idle_errors();
        send_item(ACT_DELIVER, 3'd0, '0, 8'h00);
        send_item(ACT_BAD, 3'd7, -1, 8'hFF);
    endtask

    // Lane count below range, every lane empty at priming
    task automatic test_all_exhausted();
        set_lane_count(4'd0);
        send_item(ACT_START, 3'd0, '0, 8'h00);
        send_item(ACT_EXHAUST, 3'd0, '0, 8'h00);
        send_item(ACT_EXHAUST, 3'd1, '0, 8'h00);
    endtask

    // Key extremes, equal refill, falling refills, reopen and lane exhaustion
    task automatic test_extreme_keys();
        set_lane_count(4'd2);
        send_item(ACT_START, 3'd0, '0, 8'h00);
        send_item(ACT_DELIVER, 3'd0, KEY_MAX, 8'hFF);
        send_item(ACT_DELIVER, 3'd1, KEY_MIN, 8'h00);
        send_item(ACT_DELIVER, 3'd0, 5, 8'h11);
        send_item(ACT_DELIVER, 3'd1, KEY_MIN, 8'h5A);
        send_item(ACT_BAD, 3'd1, 0, 8'h00);
        send_item(ACT_DELIVER, 3'd1, 5, 8'hA5);
        send_item(ACT_DELIVER, 3'd1, -3, 8'h3C);
        send_item(ACT_DELIVER, 3'd0, 0, 8'hC3);
        send_item(ACT_EXHAUST, 3'd1, '0, 8'h00);
        send_item(ACT_EXHAUST, 3'd0, '0, 8'h00);
    endtask

    // Lane count above range, tied heads, priming out of order, abandoned pass
    task automatic test_wide_pass();
        set_lane_count(4'd15);
        send_item(ACT_START, 3'd0, '0, 8'h00);
        for (int k = 0; k < LANES; k++) begin
            if (k == 2)
                send_item(ACT_DELIVER, 3'd5, 7, 8'h77);
            if (k == 3)
                send_item(ACT_EXHAUST, LID_W'(k), '0, 8'h00);
            else
                send_item(ACT_DELIVER, LID_W'(k), 7, TAG_W'(k));
        end
        send_item(ACT_DELIVER, 3'd0, 7, 8'h80);
        send_item(ACT_START, 3'd7, -1, 8'hFF);
    endtask

    // One pass with random streams, noise and an occasional abandon
    task automatic run_random_pass();
        logic [LID_W-1:0] ln;
        if (merge_state == MS_IDLE && $urandom_range(0, 3) == 0)
            set_lane_count(CFG_W'($urandom_range(0, 15)));
        if (merge_state == MS_IDLE && $urandom_range(0, 7) == 0)
            send_item(ACT_DELIVER, LID_W'($urandom_range(0, 7)), $urandom,
                      TAG_W'($urandom_range(0, 255)));
        key_style = key_style_t'($urandom_range(0, 3));
        send_item(ACT_START, LID_W'($urandom_range(0, 7)), $urandom,
                  TAG_W'($urandom_range(0, 255)));
        for (int k = 0; k < pass_width; k++) begin
            if ($urandom_range(0, 19) == 0)
                send_noise(LID_W'(k));
            if ($urandom_range(0, 5) == 0) begin
                lane_left[k] = 0;
                send_item(ACT_EXHAUST, LID_W'(k), $urandom, TAG_W'($urandom_range(0, 255)));
            end else begin
                lane_left[k] = $urandom_range(0, 12);
                lane_last[k] = KEY_W'($urandom_range(0, 2000)) - 1000;
                send_item(ACT_DELIVER, LID_W'(k), next_key(k), TAG_W'($urandom_range(0, 255)));
            end
        end
        while (merge_state == MS_REFILL) begin
            if ($urandom_range(0, 19) == 0)
                send_noise(want_lane);
            // leave the pass hanging; the next start abandons it
            if ($urandom_range(0, 99) == 0)
                return;
            ln = want_lane;
            if (lane_left[ln] == 0) begin
                send_item(ACT_EXHAUST, ln, $urandom, TAG_W'($urandom_range(0, 255)));
            end else begin
                lane_left[ln]--;
                send_item(ACT_DELIVER, ln, next_key(ln), TAG_W'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_random_passes();
        while (items_sent < ITEM_TARGET)
            run_random_pass();
    endtask

    // Stall the result channel: open stretches, choppy ready, long stalls
    always @(posedge clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    rsp_if.ready <= 1'b1;
                    ready_hold   <= $urandom_range(20, 120);
                end
                3, 4, 5, 6: begin
                    rsp_if.ready <= ~rsp_if.ready;
                    ready_hold   <= $urandom_range(0, 3);
                end
                default: begin
                    rsp_if.ready <= 1'b0;
                    ready_hold   <= $urandom_range(1, 30);
                end
            endcase
        end
    end

    function automatic void field_check(input string field,
                                        input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    // Compare each accepted result with the oldest expectation
    always @(posedge clk) begin
        result_t want;
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (due_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_CAP)
                    $display("%0t: unexpected result, expected none, got kind %0d key %0d",
                             $time, rsp_if.kind, rsp_if.out_key);
            end else begin
                want = due_results.pop_front();
                case (want.kind)
                    KIND_ELEM: elems_seen++;
                    KIND_DONE: dones_seen++;
                    default:   errors_seen++;
                endcase
                field_check("kind", {62'd0, want.kind}, {62'd0, rsp_if.kind});
                field_check("out_key", 64'(want.key), 64'(rsp_if.out_key));
                field_check("out_tag", {56'd0, want.tag}, {56'd0, rsp_if.out_tag});
                field_check("source_lane", {61'd0, want.lane}, {61'd0, rsp_if.source_lane});
                field_check("new_run", {63'd0, want.new_run}, {63'd0, rsp_if.new_run});
            end
        end
    end

    // End the run when no item moves on either channel for too long
    always @(posedge clk) begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        req_if.valid  = 1'b0;
        req_if.action = ACT_DELIVER;
        req_if.lane   = '0;
        req_if.key    = '0;
        req_if.tag    = '0;
        rsp_if.ready  = 1'b0;
        ready_hold    = 0;
        burst_left    = 0;
        items_sent    = 0;
        fail_count    = 0;
        elems_seen    = 0;
        dones_seen    = 0;
        errors_seen   = 0;
        quiet_cycles  = 0;
        codes_written = '0;
        key_style     = KS_TIES;
        for (int i = 0; i < LANES; i++) begin
            lane_left[i] = 0;
            lane_last[i] = '0;
        end

        // Predictor starts from the reset state
        lanes_reg   = CFG_W'(MIN_LANES);
        pass_width  = MIN_LANES;
        merge_state = MS_IDLE;
        open_pass();
        fresh_run = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_errors();
        test_all_exhausted();
        test_extreme_keys();
        test_wide_pass();
        test_random_passes();
        wait_quiet();

        $display("Sent %0d items over %0d of 16 lane-count codes", items_sent,
                 $countones(codes_written));
        $display("Checked %0d merged elements, %0d pass ends, %0d protocol errors",
                 elems_seen, dones_seen, errors_seen);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
